// ===== rtl/ipra_pkg.sv =====
// ============================================================================
// ipra_pkg
// Shared constants, codes and controller/datapath interface types for the
// IPv4 range allow-list core.
// ============================================================================
`default_nettype none

package ipra_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int ACT_W       = 3;
   localparam int PLEN_W      = 6;
   localparam int STAT_W      = 2;

   localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PREFIX = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RANGE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SINGLE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

   localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              store;
      logic              clear;
      logic              scan_step;
      logic              res_load;
      logic              res_allowed;
      logic [STAT_W-1:0] res_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             count_zero;
      logic             full;
      logic             addr_zero;
      logic             ins_invalid;
      logic             hit;
      logic             exhausted;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/ipv4_range_allowlist_core.sv =====
// ============================================================================
// ipv4_range_allowlist_core
// IPv4 allow list holding up to TABLE_DEPTH address ranges, with prefix,
// range and single-address inserts, table clear and address check.
// ============================================================================
// Sequencing: an accepted request passes through DECODE and then RESP,
// where the result is registered once the response side is free; a check
// that scans the stored ranges visits SCAN in between, one table read per cycle.
// One transaction at a time: a new request is taken only once the result
// has been handed to the response register and the controller is idle.
// Reset (synchronous, active high) empties the table and drops any pending
// result; table contents themselves are not cleared.
`default_nettype none

module ipv4_range_allowlist_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [ipra_pkg::ACT_W-1:0]    req_action,
   input  wire logic [ipra_pkg::ADDR_W-1:0]   req_addr_a,
   input  wire logic [ipra_pkg::ADDR_W-1:0]   req_addr_b,
   input  wire logic [ipra_pkg::PLEN_W-1:0]   req_prefix_len,
   // Response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_allowed,
   output      logic [ipra_pkg::STAT_W-1:0]   rsp_status
);

   // The controller owns the handshakes and the sequencing; the datapath
   // owns the transaction fields, the range table and the result payload.
   // The response register decouples the two sides: a finished result may
   // wait under stall while the controller sits idle.
   ipra_pkg::dp_cmd_type    cmd;
   ipra_pkg::dp_status_type status;

   ipra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // A check walks the stored ranges in insertion order, issuing one table
   // read per cycle and comparing the previous read, and stops on the first
   // match or once every stored entry has been compared.
   ipra_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_addr_a     (req_addr_a),
      .req_addr_b     (req_addr_b),
      .req_prefix_len (req_prefix_len),
      .rsp_allowed    (rsp_allowed),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/ipra_dp.sv =====
// ============================================================================
// ipra_dp
// Datapath: transaction field registers, range table memory, scan compare
// and the result payload register.
// ============================================================================
`default_nettype none

module ipra_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ipra_pkg::dp_cmd_type          cmd,
   output      ipra_pkg::dp_status_type       status,
   input  wire logic [ipra_pkg::ACT_W-1:0]    req_action,
   input  wire logic [ipra_pkg::ADDR_W-1:0]   req_addr_a,
   input  wire logic [ipra_pkg::ADDR_W-1:0]   req_addr_b,
   input  wire logic [ipra_pkg::PLEN_W-1:0]   req_prefix_len,
   output      logic                          rsp_allowed,
   output      logic [ipra_pkg::STAT_W-1:0]   rsp_status
);

   logic [ipra_pkg::ACT_W-1:0]   act_ff;
   logic [ipra_pkg::ADDR_W-1:0]  a_ff;
   logic [ipra_pkg::ADDR_W-1:0]  b_ff;
   logic [ipra_pkg::PLEN_W-1:0]  plen_ff;

   logic [ipra_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ipra_pkg::COUNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [ipra_pkg::ADDR_W-1:0]  rd_lo_ff;
   logic [ipra_pkg::ADDR_W-1:0]  rd_hi_ff;
   logic                         rd_issue;

   logic                         allowed_ff;
   logic [ipra_pkg::STAT_W-1:0]  status_ff;

   logic [ipra_pkg::ADDR_W-1:0]  lo_mem [ipra_pkg::TABLE_DEPTH];
   logic [ipra_pkg::ADDR_W-1:0]  hi_mem [ipra_pkg::TABLE_DEPTH];

   logic [ipra_pkg::ADDR_W-1:0]  mask;
   logic [ipra_pkg::ADDR_W-1:0]  ins_lo;
   logic [ipra_pkg::ADDR_W-1:0]  ins_hi;
   logic                         ins_invalid;
   logic                         a_zero;
   logic                         b_zero;
   logic                         hit;

   assign a_zero = (a_ff == '0);
   assign b_zero = (b_ff == '0);

   // Network mask for a prefix; a zero length covers the whole space.
   always_comb begin
      if (plen_ff == '0 || plen_ff > ipra_pkg::MAX_PLEN) begin
         mask = '0;
      end else begin
         mask = {ipra_pkg::ADDR_W{1'b1}} << (ipra_pkg::MAX_PLEN - plen_ff);
      end
   end

   always_comb begin
      case (act_ff)
         ipra_pkg::ACT_PREFIX: begin
            ins_lo = a_ff & mask;
            ins_hi = (a_ff & mask) | ~mask;
         end
         ipra_pkg::ACT_RANGE: begin
            ins_lo = a_ff;
            ins_hi = b_ff;
         end
         default: begin
            ins_lo = a_ff;
            ins_hi = a_ff;
         end
      endcase
   end

   always_comb begin
      case (act_ff)
         ipra_pkg::ACT_PREFIX: ins_invalid = a_zero || (plen_ff > ipra_pkg::MAX_PLEN);
         ipra_pkg::ACT_RANGE:  ins_invalid = a_zero || b_zero || (a_ff > b_ff);
         ipra_pkg::ACT_SINGLE: ins_invalid = a_zero;
         default:              ins_invalid = 1'b0;
      endcase
   end

   assign hit = rd_vld_ff && (a_ff >= rd_lo_ff) && (a_ff <= rd_hi_ff);

   assign status.act         = act_ff;
   assign status.count_zero  = (count_ff == '0);
   assign status.full        = (count_ff == ipra_pkg::COUNT_W'(ipra_pkg::TABLE_DEPTH));
   assign status.addr_zero   = a_zero;
   assign status.ins_invalid = ins_invalid;
   assign status.hit         = hit;
   assign status.exhausted   = (rd_idx_ff == count_ff) && !hit;

   assign rd_issue = cmd.scan_step && !hit && (rd_idx_ff != count_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.store) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      rd_vld_in = rd_vld_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         rd_vld_in = 1'b0;
      end else if (cmd.scan_step) begin
         rd_vld_in = rd_issue;
         if (rd_issue) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         a_ff    <= req_addr_a;
         b_ff    <= req_addr_b;
         plen_ff <= req_prefix_len;
      end
      if (cmd.res_load) begin
         allowed_ff <= cmd.res_allowed;
         status_ff  <= cmd.res_status;
      end
   end

   // Range table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         lo_mem[count_ff[ipra_pkg::IDX_W-1:0]] <= ins_lo;
         hi_mem[count_ff[ipra_pkg::IDX_W-1:0]] <= ins_hi;
      end
      if (rd_issue) begin
         rd_lo_ff <= lo_mem[rd_idx_ff[ipra_pkg::IDX_W-1:0]];
         rd_hi_ff <= hi_mem[rd_idx_ff[ipra_pkg::IDX_W-1:0]];
      end
   end

   assign rsp_allowed = allowed_ff;
   assign rsp_status  = status_ff;

endmodule

`default_nettype wire

// ===== rtl/ipra_ctrl.sv =====
// ============================================================================
// ipra_ctrl
// Controller: sequences decode, table scan and result hand-off for one
// transaction at a time.
// ============================================================================
`default_nettype none

module ipra_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      ipra_pkg::dp_cmd_type    cmd,
   input  wire ipra_pkg::dp_status_type status
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        res_allowed_ff, res_allowed_in;
   logic [ipra_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic                        out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      res_allowed_in  = res_allowed_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      cmd             = '0;
      cmd.res_allowed = res_allowed_ff;
      cmd.res_status  = res_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_allowed_in = 1'b0;
            res_status_in  = ipra_pkg::ST_DONE;
            state_in       = S_RESP;
            case (status.act)
               ipra_pkg::ACT_CHECK: begin
                  if (status.count_zero) begin
                     res_allowed_in = 1'b1;
                  end else if (!status.addr_zero) begin
                     state_in = S_SCAN;
                  end
               end
               ipra_pkg::ACT_PREFIX, ipra_pkg::ACT_RANGE, ipra_pkg::ACT_SINGLE: begin
                  if (status.ins_invalid) begin
                     res_status_in = ipra_pkg::ST_INVALID;
                  end else if (status.full) begin
                     res_status_in = ipra_pkg::ST_FULL;
                  end else begin
                     cmd.store = 1'b1;
                  end
               end
               ipra_pkg::ACT_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  res_status_in = ipra_pkg::ST_INVALID;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               res_allowed_in = 1'b1;
               state_in       = S_RESP;
            end else if (status.exhausted) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_allowed_ff <= res_allowed_in;
      res_status_ff  <= res_status_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/ipra_checker.sv =====
// ============================================================================
// ipra_checker
// Port-level checks for the IPv4 range allow-list core.
// ============================================================================
`default_nettype none

module ipra_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic                        rsp_allowed,
   input wire logic [ipra_pkg::STAT_W-1:0] rsp_status
);

   // A response under stall is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A rejected or unknown transaction never reports an allowed address.
   a_reject_not_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ipra_pkg::ST_DONE) |-> !rsp_allowed)
      else $error("allowed set on a rejected transaction");

   // Status code three is never produced.
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ipra_pkg::ST_UNUSED))
      else $error("illegal response status");

   // One transaction at a time: an accepted request stalls the next one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a transaction is in flight");

endmodule

bind ipv4_range_allowlist_core ipra_checker u_ipra_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_allowed (rsp_allowed),
   .rsp_status  (rsp_status)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the IPv4 range allow list. A scoreboard keeps its
// own copy of the range table and predicts the verdict of every transaction
// that the core accepts. A directed opening covers the corner cases, and
// random insert and check bursts with idling on both channels follow.
// ============================================================================

module testbench;
   import ipra_pkg::*;

   // Action codes that the core does not define. It must answer them with
   // a rejection and leave the table alone.
   localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

   localparam int ITEM_TARGET   = 1600;
   localparam int MAX_IDLE      = 7;
   // The slowest transaction is a full scan plus the longest idle gap on each
   // side, so STALL_LIMIT quiet cycles can only mean a hang.
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOT_DEPTH     = 64;

   typedef struct packed {
      logic              allowed;
      logic [STAT_W-1:0] status;
   } verdict_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a private copy of the range table, plus the queue of verdicts
   // that the core still owes us, in order of acceptance.
   // -------------------------------------------------------------------------
   class allowlist_scoreboard;
      logic [ADDR_W-1:0] range_lo [TABLE_DEPTH];
      logic [ADDR_W-1:0] range_hi [TABLE_DEPTH];
      int unsigned       entries;
      verdict_type       expected_verdicts [$];
      int unsigned       errors;

      function new();
         entries = 0;
         errors  = 0;
      endfunction

      function logic address_permitted(logic [ADDR_W-1:0] addr);
         if (entries == 0) return 1'b1;
         if (addr == '0) return 1'b0;
         for (int i = 0; i < entries; i++) begin
            if (addr >= range_lo[i] && addr <= range_hi[i]) return 1'b1;
         end
         return 1'b0;
      endfunction

      function logic [STAT_W-1:0] store_range(logic [ADDR_W-1:0] lo,
                                              logic [ADDR_W-1:0] hi);
         if (entries >= TABLE_DEPTH) return ST_FULL;
         range_lo[entries] = lo;
         range_hi[entries] = hi;
         entries++;
         return ST_DONE;
      endfunction

      function void note_request(logic [ACT_W-1:0] action, logic [ADDR_W-1:0] addr_a,
                                 logic [ADDR_W-1:0] addr_b, logic [PLEN_W-1:0] plen);
         verdict_type       v;
         logic [ADDR_W-1:0] mask;
         logic [ADDR_W-1:0] base;
         v.allowed = 1'b0;
         v.status  = ST_DONE;
         case (action)
            ACT_CHECK: v.allowed = address_permitted(addr_a);
            ACT_PREFIX: begin
               if (addr_a == '0 || plen > MAX_PLEN) begin
                  v.status = ST_INVALID;
               end else begin
                  mask     = (plen == '0) ? '0 : ('1 << (32 - plen));
                  base     = addr_a & mask;
                  v.status = store_range(base, base | ~mask);
               end
            end
            ACT_RANGE: begin
               if (addr_a == '0 || addr_b == '0 || addr_a > addr_b) v.status = ST_INVALID;
               else v.status = store_range(addr_a, addr_b);
            end
            ACT_SINGLE: begin
               if (addr_a == '0) v.status = ST_INVALID;
               else v.status = store_range(addr_a, addr_a);
            end
            ACT_CLEAR: entries = 0;
            default: v.status = ST_INVALID;
         endcase
         expected_verdicts.insert(expected_verdicts.size(), v);
      endfunction

      function void check_verdict(logic allowed, logic [STAT_W-1:0] status);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result with no transaction outstanding: allowed %0b status %0d",
                     $time, allowed, status);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (allowed !== want.allowed) begin
            $display("%0t: allowed mismatch: expected %0b, actual %0b",
                     $time, want.allowed, allowed);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_verdicts.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the device under test
   // -------------------------------------------------------------------------
   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACT_W-1:0]    req_action;
   logic [ADDR_W-1:0]   req_addr_a;
   logic [ADDR_W-1:0]   req_addr_b;
   logic [PLEN_W-1:0]   req_prefix_len;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_allowed;
   logic [STAT_W-1:0]   rsp_status;

   allowlist_scoreboard sb = new();

   // When clear, neither side idles, so that back-to-back transactions occur.
   logic                idle_enable;
   int unsigned         items_sent;
   int unsigned         quiet_cycles;
   // Addresses close to the edges of recently inserted ranges. Checks draw
   // from here so that most of them land on a boundary rather than far away.
   logic [ADDR_W-1:0]   hot_addrs [$];

   ipv4_range_allowlist_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_addr_a     (req_addr_a),
      .req_addr_b     (req_addr_b),
      .req_prefix_len (req_prefix_len),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_allowed    (rsp_allowed),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor. Both channels are sampled at the rising edge only, so the
   // prediction sees exactly the transactions that the core accepted. Any
   // cycle with no handshake on either side feeds the hang watchdog.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            sb.note_request(req_action, req_addr_a, req_addr_b, req_prefix_len);
         if (rsp_valid && !rsp_stall)
            sb.check_verdict(rsp_allowed, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side. For every result it draws a number of cycles to hold stall
   // high, then lets the next result through. Since the draw starts as soon
   // as the previous result has gone, the stall sometimes expires before the
   // next result exists and sometimes holds it back.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         hold = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Request side. Inputs change only on the falling edge. When the drawn gap
   // is zero, valid simply stays high into the next transaction.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic [ACT_W-1:0] action,
                               input logic [ADDR_W-1:0] addr_a,
                               input logic [ADDR_W-1:0] addr_b,
                               input logic [PLEN_W-1:0] plen);
      int unsigned gap;
      gap = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_action     = action;
      req_addr_a     = addr_a;
      req_addr_b     = addr_b;
      req_prefix_len = plen;
      do @(posedge clock); while (req_stall);
      if (action <= ACT_CLEAR) items_sent++;
   endtask

   // Stop sending until every owed result has come back, then hold off
   // for a randomly drawn idle gap so that the core sits fully idle.
   task automatic drain_requests();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat ($urandom_range(1, 8)) @(negedge clock);
   endtask

   // Random address, with some weight on both ends of the address space.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom_range(1, 255);
      if (sel == 1) return 32'hFFFF_FF00 | $urandom_range(0, 255);
      return $urandom();
   endfunction

   function automatic logic [ADDR_W-1:0] pick_check_address();
      if (hot_addrs.size() != 0 && $urandom_range(0, 9) < 6)
         return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
      if ($urandom_range(0, 19) == 0) return '0;
      return pick_address();
   endfunction

   function automatic void note_hot(logic [ADDR_W-1:0] addr);
      hot_addrs.insert(hot_addrs.size(), addr);
      if (hot_addrs.size() > HOT_DEPTH) void'(hot_addrs.pop_front());
   endfunction

   task automatic random_check();
      send_request(ACT_CHECK, pick_check_address(), $urandom(),
                   PLEN_W'($urandom_range(0, 63)));
   endtask

   // One insert of a random kind. About one in ten inserts is malformed, and
   // a tenth of these calls send plain noise, including the undefined actions.
   task automatic random_insert();
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] host;
      logic [PLEN_W-1:0] plen;
      longint unsigned   upper;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      a    = pick_address();
      if (pick < 35) begin
         plen = ($urandom_range(0, 32) == 0) ? '0 : PLEN_W'($urandom_range(4, 32));
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) != 0) a = '0;
            else plen = PLEN_W'($urandom_range(33, 63));
         end
         send_request(ACT_PREFIX, a, $urandom(), plen);
         host = (plen >= MAX_PLEN) ? '0 : ('1 >> plen);
         note_hot((a & ~host) - 1);
         note_hot(a & ~host);
         note_hot(a | host);
         note_hot((a | host) + 1);
      end else if (pick < 65) begin
         upper = longint'(a) + $urandom_range(0, 1 << $urandom_range(0, 24));
         b     = (upper > 64'hFFFF_FFFF) ? '1 : upper[ADDR_W-1:0];
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: a = '0;
               1: b = '0;
               default: {a, b} = {b, a};
            endcase
         end
         send_request(ACT_RANGE, a, b, PLEN_W'($urandom_range(0, 63)));
         note_hot(a - 1);
         note_hot(a);
         note_hot(b);
         note_hot(b + 1);
      end else if (pick < 90) begin
         if ($urandom_range(0, 9) == 0) a = '0;
         send_request(ACT_SINGLE, a, $urandom(), PLEN_W'($urandom_range(0, 63)));
         note_hot(a - 1);
         note_hot(a);
         note_hot(a + 1);
      end else begin
         send_request(ACT_W'($urandom_range(0, 7)), $urandom(), $urandom(),
                      PLEN_W'($urandom_range(0, 63)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned burst;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_CHECK;
      req_addr_a     = '0;
      req_addr_b     = '0;
      req_prefix_len = '0;
      idle_enable    = 1'b1;
      items_sent     = 0;
      quiet_cycles   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening. While the table is empty every address passes,
      // zero included.
      send_request(ACT_CHECK, 32'h0000_0000, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      // Malformed inserts of each kind: none of them may reach the table.
      send_request(ACT_PREFIX, 32'h0000_0000, 32'h0000_0000, 6'd8);
      send_request(ACT_PREFIX, 32'h0A01_0203, 32'h0000_0000, 6'd33);
      send_request(ACT_PREFIX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      send_request(ACT_RANGE, 32'h0000_0000, 32'h0000_0005, 6'd0);
      send_request(ACT_RANGE, 32'h0000_0005, 32'h0000_0000, 6'd0);
      send_request(ACT_RANGE, 32'h0000_0009, 32'h0000_0008, 6'd0);
      send_request(ACT_SINGLE, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
      for (int code = ACT_UNUSED_FIRST; code <= ACT_UNUSED_LAST; code++)
         send_request(ACT_W'(code), 32'h1234_5678, 32'h9ABC_DEF0, 6'd16);
      send_request(ACT_CHECK, 32'h1234_5678, 32'h0000_0000, 6'd0);
      // A /8 prefix whose base has host bits set: they must be masked off.
      send_request(ACT_PREFIX, 32'h0A01_02FF, 32'h0000_0000, 6'd8);
      send_request(ACT_CHECK, 32'h0000_0000, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h0AFF_FFFF, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h0B00_0000, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h09FF_FFFF, 32'h0000_0000, 6'd0);
      send_request(ACT_PREFIX, 32'hC0A8_0001, 32'h0000_0000, 6'd32);
      // A one-address range, and a single address at the very top.
      send_request(ACT_RANGE, 32'h0000_0001, 32'h0000_0001, 6'd0);
      send_request(ACT_CHECK, 32'h0000_0001, 32'h0000_0000, 6'd0);
      send_request(ACT_SINGLE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
      // After a clear the table is empty again and lets everything through.
      send_request(ACT_CLEAR, 32'h0000_0000, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h0000_0000, 32'h0000_0000, 6'd0);
      // A zero-length prefix spans the whole space, but zero is still refused.
      send_request(ACT_PREFIX, 32'h8000_0000, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h0000_0002, 32'h0000_0000, 6'd0);
      send_request(ACT_CHECK, 32'h0000_0000, 32'h0000_0000, 6'd0);
      drain_requests();

      // Random part. Each round usually starts from a clear table and then
      // builds it up with a burst of inserts, sprinkling boundary checks in
      // between. Bursts longer than the table depth can push it into the full
      // state, where both well-formed and malformed inserts are tried.
      // Rounds that skip the clear keep the table left by the round before.
      while (items_sent < ITEM_TARGET) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            send_request(ACT_CLEAR, $urandom(), $urandom(), PLEN_W'($urandom_range(0, 63)));
            hot_addrs.delete();
         end
         burst = $urandom_range(0, 20);
         repeat (burst) begin
            random_insert();
            repeat ($urandom_range(0, 2)) random_check();
         end
         repeat ($urandom_range(2, 8)) random_check();
         if ($urandom_range(0, 9) == 0) drain_requests();
      end

      // Wind down: stop sending, collect every outstanding verdict, then give
      // the core time to show any stray result before the verdict is printed.
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
